FILE: rtl/mam_pkg.sv
// Shared types and constants of the Manchester ASK modulator.
package mam_pkg;

  // Kind of an accepted input beat
  typedef enum logic {
    OP_TICK = 1'b0,
    OP_BYTE = 1'b1
  } cmd_op_e;

  // Classified item handed from the front end to the back end
  typedef struct packed {
    cmd_op_e    op;
    logic [7:0] data;
  } cmd_t;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_COEF_CUR   = 3'd0,
    REG_COEF_PREV  = 3'd1,
    REG_START_CUR  = 3'd2,
    REG_START_PREV = 3'd3,
    REG_HALF_LEN   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic signed [7:0]  coef_cur;
    logic signed [7:0]  coef_prev;
    logic signed [15:0] start_cur;
    logic signed [15:0] start_prev;
    logic        [15:0] half_len;
  } cfg_t;

  localparam logic signed [7:0]  CoefCurRst   = 8'sd15;
  localparam logic signed [7:0]  CoefPrevRst  = -8'sd8;
  localparam logic signed [15:0] StartCurRst  = 16'sd31;
  localparam logic signed [15:0] StartPrevRst = -16'sd79;
  localparam logic        [15:0] HalfLenRst   = 16'd100;

  // Zero level of the unsigned sample stream
  localparam logic [7:0] SampleZero = 8'd128;

  // Front-end command queue
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = 1;
  localparam int unsigned QueueCntW  = 2;

endpackage

FILE: rtl/mam_if.sv
// Channel interfaces of the Manchester ASK modulator: input items, samples, register writes.
interface mam_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] byte_value;

  modport source (output valid, output opcode, output byte_value, input ready);
  modport sink   (input valid, input opcode, input byte_value, output ready);
endinterface

interface mam_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] sample;
  logic       clock_level;
  logic       busy_res;

  modport source (output valid, output sample, output clock_level, output busy_res,
                  input ready);
  modport sink   (input valid, input sample, input clock_level, input busy_res,
                  output ready);
endinterface

interface mam_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [mam_pkg::CfgIdxW-1:0]  index;
  logic [mam_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/mam_front.sv
// Front end: accepts input beats, classifies them and queues them for the back end.
module mam_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  mam_in_if.sink        in_chan_i,
  output logic          cmd_valid_o,
  output mam_pkg::cmd_t cmd_o,
  input  logic          cmd_ready_i
);

  mam_pkg::cmd_t                       queue_q [mam_pkg::QueueDepth];
  logic [mam_pkg::QueuePtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [mam_pkg::QueuePtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [mam_pkg::QueueCntW-1:0]       count_q, count_d;
  logic                                push, pop;
  mam_pkg::cmd_t                       cmd_in;

  assign in_chan_i.ready = (count_q != mam_pkg::QueueCntW'(mam_pkg::QueueDepth));
  assign push            = in_chan_i.valid && in_chan_i.ready;
  assign cmd_valid_o     = (count_q != '0);
  assign pop             = cmd_valid_o && cmd_ready_i;
  assign cmd_o           = queue_q[rd_ptr_q];

  always_comb begin
    cmd_in.op   = in_chan_i.opcode ? mam_pkg::OP_BYTE : mam_pkg::OP_TICK;
    cmd_in.data = in_chan_i.byte_value;
  end

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

FILE: rtl/mam_back.sv
// Back end: frame sequencer, Manchester half-bit timer, resonator and output register.
module mam_back #(
  parameter int unsigned BITS_PER_CHAR = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mam_pkg::cfg_t cfg_i,
  input  logic          cmd_valid_i,
  input  mam_pkg::cmd_t cmd_i,
  output logic          cmd_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    sample_o,
  output logic          clock_level_o,
  output logic          busy_res_o
);

  localparam int unsigned BitsW = $clog2(BITS_PER_CHAR + 1);

  logic signed [15:0] osc_cur_q, osc_cur_d;
  logic signed [15:0] osc_prev_q, osc_prev_d;
  logic [15:0]        half_left_q, half_left_d;
  logic               carrier_q, carrier_d;
  logic               second_q, second_d;
  logic [BitsW-1:0]   bits_left_q, bits_left_d;
  logic [7:0]         shift_q, shift_d;
  logic               sending_q, sending_d;
  logic [7:0]         pend_byte_q, pend_byte_d;
  logic               pend_valid_q, pend_valid_d;
  logic               clk_lvl_q, clk_lvl_d;
  logic               out_valid_q, out_valid_d;
  logic [7:0]         sample_q;
  logic               busy_q;

  logic               cmd_take, tick_take;
  logic signed [23:0] prod_cur, prod_prev;
  logic signed [24:0] res_sum;
  logic [15:0]        res_new;
  logic [15:0]        half_dec;
  logic [4:0]         bit_idx;
  logic               data_bit;
  logic [7:0]         smp;

  assign cmd_ready_o = (cmd_i.op == mam_pkg::OP_BYTE) || !out_valid_q || out_ready_i;
  assign cmd_take    = cmd_valid_i && cmd_ready_o;
  assign tick_take   = cmd_take && (cmd_i.op == mam_pkg::OP_TICK);

  // Resonator: floor divide by eight of the weighted sum, wrapped to 16 bits
  assign prod_cur  = cfg_i.coef_cur * osc_cur_q;
  assign prod_prev = cfg_i.coef_prev * osc_prev_q;
  assign res_sum   = 25'(prod_cur) + 25'(prod_prev);
  assign res_new   = res_sum[18:3];

  assign half_dec  = half_left_q - 16'd1;
  assign bit_idx   = 5'(bits_left_q) - 5'd1;
  // Data bits past the eighth go out as zero
  assign data_bit  = (bit_idx < 5'd8) ? shift_q[bit_idx[2:0]] : 1'b0;

  always_comb begin
    osc_cur_d    = osc_cur_q;
    osc_prev_d   = osc_prev_q;
    half_left_d  = half_left_q;
    carrier_d    = carrier_q;
    second_d     = second_q;
    bits_left_d  = bits_left_q;
    shift_d      = shift_q;
    sending_d    = sending_q;
    pend_byte_d  = pend_byte_q;
    pend_valid_d = pend_valid_q;
    clk_lvl_d    = clk_lvl_q;
    smp          = mam_pkg::SampleZero;

    if (cmd_take && (cmd_i.op == mam_pkg::OP_BYTE)) begin
      if (!sending_q) begin
        shift_d     = cmd_i.data;
        sending_d   = 1'b1;
        bits_left_d = BitsW'(BITS_PER_CHAR);
        second_d    = 1'b0;
        carrier_d   = 1'b0;
        half_left_d = cfg_i.half_len;
        osc_cur_d   = '0;
        osc_prev_d  = '0;
      end else begin
        pend_byte_d  = cmd_i.data;
        pend_valid_d = 1'b1;
      end
    end else if (tick_take) begin
      if (sending_q) begin
        if (carrier_q) begin
          osc_prev_d = osc_cur_q;
          osc_cur_d  = res_new;
          smp        = res_new[7:0] + mam_pkg::SampleZero;
        end
        half_left_d = half_dec;
        if (half_dec == '0) begin
          if (!second_q) begin
            // Move to the second half with the carrier flipped
            second_d    = 1'b1;
            carrier_d   = !carrier_q;
            half_left_d = cfg_i.half_len;
            osc_cur_d   = !carrier_q ? cfg_i.start_cur : '0;
            osc_prev_d  = !carrier_q ? cfg_i.start_prev : '0;
          end else if (bits_left_q != '0) begin
            // Next data bit: a one opens with a low half
            second_d    = 1'b0;
            bits_left_d = bits_left_q - 1'b1;
            carrier_d   = !data_bit;
            half_left_d = cfg_i.half_len;
            osc_cur_d   = !data_bit ? cfg_i.start_cur : '0;
            osc_prev_d  = !data_bit ? cfg_i.start_prev : '0;
          end else begin
            // End of frame: drop to idle, or chain the pending byte at once
            second_d    = 1'b0;
            sending_d   = 1'b0;
            carrier_d   = 1'b0;
            osc_cur_d   = '0;
            osc_prev_d  = '0;
            half_left_d = '0;
            if (pend_valid_q) begin
              pend_valid_d = 1'b0;
              shift_d      = pend_byte_q;
              sending_d    = 1'b1;
              bits_left_d  = BitsW'(BITS_PER_CHAR);
              half_left_d  = cfg_i.half_len;
            end
          end
        end
      end
      clk_lvl_d = !clk_lvl_q;
    end
  end

  assign out_valid_d = tick_take || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      osc_cur_q    <= '0;
      osc_prev_q   <= '0;
      half_left_q  <= '0;
      carrier_q    <= 1'b0;
      second_q     <= 1'b0;
      bits_left_q  <= '0;
      shift_q      <= '0;
      sending_q    <= 1'b0;
      pend_byte_q  <= '0;
      pend_valid_q <= 1'b0;
      clk_lvl_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      osc_cur_q    <= osc_cur_d;
      osc_prev_q   <= osc_prev_d;
      half_left_q  <= half_left_d;
      carrier_q    <= carrier_d;
      second_q     <= second_d;
      bits_left_q  <= bits_left_d;
      shift_q      <= shift_d;
      sending_q    <= sending_d;
      pend_byte_q  <= pend_byte_d;
      pend_valid_q <= pend_valid_d;
      clk_lvl_q    <= clk_lvl_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_take) begin
      sample_q <= smp;
      busy_q   <= sending_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign sample_o      = sample_q;
  assign clock_level_o = clk_lvl_q;
  assign busy_res_o    = busy_q;

  a_idle_no_carrier: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sending_q |-> (!carrier_q && !pend_valid_q))
    else $error("carrier or pending byte while idle");

  a_idle_tick_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_take && !sending_q) |=> (sample_q == mam_pkg::SampleZero && !busy_q))
    else $error("idle tick gave a non-zero sample");

  a_clock_toggles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_take |=> (clk_lvl_q != $past(clk_lvl_q)))
    else $error("clock level did not toggle on a tick");

  a_bits_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bits_left_q <= BitsW'(BITS_PER_CHAR))
    else $error("bit counter beyond frame length");

endmodule

FILE: rtl/manchester_ask_modulator.sv
// Top level of the Manchester ASK modulator: register file, front end and back end.
// Each input beat is either a byte to send or a sample tick; every tick yields one sample
// beat, a byte yields none. One beat is taken per clock cycle in sustained operation while
// the output is not stalled: the limit is the resonator in the back end, which does one
// update (two 8x16 multiplies and an add) per cycle, and each tick's state feeds the next.
// A tick passes through the two-entry command queue and then the output register before
// its sample beat appears. Register writes are taken at any time but must only be issued
// while no beat is outstanding; unknown register indexes are ignored.
module manchester_ask_modulator #(
  parameter int unsigned BITS_PER_CHAR = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mam_in_if.sink    in_chan_i,
  mam_out_if.source out_chan_o,
  mam_cfg_if.sink   cfg_chan_i
);

  mam_pkg::cfg_t cfg_q;
  mam_pkg::cmd_t cmd;
  logic          cmd_valid, cmd_ready;

  assign cfg_chan_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef_cur   <= mam_pkg::CoefCurRst;
      cfg_q.coef_prev  <= mam_pkg::CoefPrevRst;
      cfg_q.start_cur  <= mam_pkg::StartCurRst;
      cfg_q.start_prev <= mam_pkg::StartPrevRst;
      cfg_q.half_len   <= mam_pkg::HalfLenRst;
    end else if (cfg_chan_i.valid) begin
      case (cfg_chan_i.index)
        mam_pkg::REG_COEF_CUR:   cfg_q.coef_cur   <= cfg_chan_i.data[7:0];
        mam_pkg::REG_COEF_PREV:  cfg_q.coef_prev  <= cfg_chan_i.data[7:0];
        mam_pkg::REG_START_CUR:  cfg_q.start_cur  <= cfg_chan_i.data;
        mam_pkg::REG_START_PREV: cfg_q.start_prev <= cfg_chan_i.data;
        mam_pkg::REG_HALF_LEN:   cfg_q.half_len   <= cfg_chan_i.data;
        default: begin
        end
      endcase
    end
  end

  mam_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_chan_i   (in_chan_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  mam_back #(
    .BITS_PER_CHAR (BITS_PER_CHAR)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .cmd_ready_o   (cmd_ready),
    .out_valid_o   (out_chan_o.valid),
    .out_ready_i   (out_chan_o.ready),
    .sample_o      (out_chan_o.sample),
    .clock_level_o (out_chan_o.clock_level),
    .busy_res_o    (out_chan_o.busy_res)
  );

endmodule

FILE: dv/mam_sample_checker.sv
`timescale 1ns / 1ps
// Sample checker: follows register writes and input beats, predicts each sample beat, compares.
module mam_sample_checker #(
  parameter int unsigned BITS_PER_CHAR = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mam_in_if           in_mon,
  mam_out_if          out_mon,
  mam_cfg_if          cfg_mon,
  output int unsigned samples_due_o,
  output int unsigned fail_count_o
);
  import mam_pkg::*;

  localparam int unsigned ReportCap = 100;

  typedef struct packed {
    logic [7:0] sample;
    logic       clock_level;
    logic       busy_res;
  } sample_beat_t;

  sample_beat_t due_samples[$];
  sample_beat_t head;

  // Own copy of the registers and of the modulator state
  cfg_t               regs;
  logic signed [15:0] osc_cur;
  logic signed [15:0] osc_prev;
  logic        [15:0] half_left;
  logic               carrier_on;
  logic               second_half;
  logic               sending;
  logic               pend_valid;
  logic               clk_lvl;
  logic         [4:0] bits_left;
  logic         [7:0] shift_byte;
  logic         [7:0] pend_byte;

  function automatic void open_half(input logic carrier);
    carrier_on = carrier;
    half_left  = regs.half_len;
    if (carrier) begin
      osc_cur  = regs.start_cur;
      osc_prev = regs.start_prev;
    end else begin
      osc_cur  = '0;
      osc_prev = '0;
    end
  endfunction

  function automatic void load_frame(input logic [7:0] value);
    shift_byte  = value;
    sending     = 1'b1;
    bits_left   = 5'(BITS_PER_CHAR);
    second_half = 1'b0;
    // the start bit is a one: low half first
    open_half(1'b0);
  endfunction

  // Full-precision sum, floored by the divide by eight, wrapped to 16 bits
  function automatic logic signed [15:0] resonate();
    int acc;
    acc = int'($signed(regs.coef_cur)) * int'(osc_cur)
        + int'($signed(regs.coef_prev)) * int'(osc_prev);
    return 16'(acc >>> 3);
  endfunction

  function automatic void next_half();
    int unsigned pos;
    logic        data_bit;
    if (!second_half) begin
      second_half = 1'b1;
      open_half(!carrier_on);
      return;
    end
    second_half = 1'b0;
    if (bits_left != 0) begin
      pos = bits_left - 1;
      // bits beyond the byte go out as zero
      data_bit = (pos < 8) ? shift_byte[pos] : 1'b0;
      bits_left--;
      open_half(!data_bit);
      return;
    end
    sending    = 1'b0;
    carrier_on = 1'b0;
    osc_cur    = '0;
    osc_prev   = '0;
    half_left  = '0;
    // a waiting byte starts on the very tick the frame ends
    if (pend_valid) begin
      pend_valid = 1'b0;
      load_frame(pend_byte);
    end
  endfunction

  function automatic void modulate_item(input cmd_op_e op, input logic [7:0] value);
    sample_beat_t       beat;
    logic signed [15:0] nv;
    if (op == OP_BYTE) begin
      if (!sending) begin
        load_frame(value);
      end else begin
        pend_byte  = value;
        pend_valid = 1'b1;
      end
      return;
    end
    beat.sample   = SampleZero;
    beat.busy_res = sending;
    if (sending) begin
      if (carrier_on) begin
        nv          = resonate();
        osc_prev    = osc_cur;
        osc_cur     = nv;
        beat.sample = nv[7:0] + SampleZero;
      end
      half_left = half_left - 16'd1;
      if (half_left == '0) next_half();
    end
    clk_lvl          = !clk_lvl;
    beat.clock_level = clk_lvl;
    due_samples.push_back(beat);
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      if (fail_count_o < ReportCap) $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs.coef_cur   = CoefCurRst;
      regs.coef_prev  = CoefPrevRst;
      regs.start_cur  = StartCurRst;
      regs.start_prev = StartPrevRst;
      regs.half_len   = HalfLenRst;
      osc_cur         = '0;
      osc_prev        = '0;
      half_left       = '0;
      carrier_on      = 1'b0;
      second_half     = 1'b0;
      sending         = 1'b0;
      pend_valid      = 1'b0;
      clk_lvl         = 1'b0;
      bits_left       = '0;
      shift_byte      = '0;
      pend_byte       = '0;
      due_samples.delete();
      samples_due_o   = 0;
      fail_count_o    = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_reg_e'(cfg_mon.index))
          REG_COEF_CUR:   regs.coef_cur   = cfg_mon.data[7:0];
          REG_COEF_PREV:  regs.coef_prev  = cfg_mon.data[7:0];
          REG_START_CUR:  regs.start_cur  = cfg_mon.data;
          REG_START_PREV: regs.start_prev = cfg_mon.data;
          REG_HALF_LEN:   regs.half_len   = cfg_mon.data;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        modulate_item(cmd_op_e'(in_mon.opcode), in_mon.byte_value);
      if (out_mon.valid && out_mon.ready) begin
        if (due_samples.size() == 0) begin
          if (fail_count_o < ReportCap)
            $error("sample beat %0d with no sample due", out_mon.sample);
          fail_count_o++;
        end else begin
          head = due_samples.pop_front();
          check_field("sample", head.sample, out_mon.sample);
          check_field("clock_level", 8'(head.clock_level), 8'(out_mon.clock_level));
          check_field("busy_res", 8'(head.busy_res), 8'(out_mon.busy_res));
        end
      end
      samples_due_o = due_samples.size();
    end
  end

endmodule

FILE: dv/tb_manchester_ask_modulator.sv
`timescale 1ns / 1ps
// Testbench top of the Manchester ASK modulator: stimulus, output back-pressure and verdict.
module tb_manchester_ask_modulator;
  import mam_pkg::*;

  localparam int unsigned BitsPerChar    = 8;
  localparam int unsigned HalvesPerFrame = 2 * (BitsPerChar + 1);
  localparam int unsigned RandPhases     = 12;
  localparam int unsigned ItemsPerPhase  = 75;
  localparam int unsigned HoldPhase      = 3;
  localparam int unsigned SinkHoldCycles = 300;
  localparam int unsigned SettleCycles   = 8;
  localparam int unsigned RegSpareLo     = int'(REG_HALF_LEN) + 1;
  localparam int unsigned RegSpareHi     = 2 ** CfgIdxW - 1;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  bit quiet      = 1'b0;
  bit sink_hold  = 1'b0;

  int unsigned samples_due;
  int unsigned fail_count;

  mam_in_if  in_chan ();
  mam_out_if out_chan ();
  mam_cfg_if cfg_chan ();

  manchester_ask_modulator #(
    .BITS_PER_CHAR(BitsPerChar)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan_i  (in_chan),
    .out_chan_o (out_chan),
    .cfg_chan_i (cfg_chan)
  );

  mam_sample_checker #(
    .BITS_PER_CHAR(BitsPerChar)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_mon        (in_chan),
    .out_mon       (out_chan),
    .cfg_mon       (cfg_chan),
    .samples_due_o (samples_due),
    .fail_count_o  (fail_count)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #60_000_000;
    $display("tb_manchester_ask_modulator: errors");
    $finish;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] draw_word(input int unsigned w);
    logic [15:0] top_bit;
    top_bit = 16'd1 << (w - 1);
    case ($urandom_range(0, 5))
      0: return top_bit;
      1: return top_bit - 16'd1;
      2: return '0;
      default: return 16'($urandom) & ((top_bit << 1) - 16'd1);
    endcase
  endfunction

  function automatic logic [7:0] draw_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic cfg_t draw_settings();
    cfg_t s;
    s.coef_cur   = 8'(draw_word(8));
    s.coef_prev  = 8'(draw_word(8));
    s.start_cur  = draw_word(16);
    s.start_prev = draw_word(16);
    s.half_len   = 16'($urandom_range(1, 6));
    return s;
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value,
                           input bit last);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= value;
    do @(posedge clk_i); while (!cfg_chan.ready);
    if (last) cfg_chan.valid <= 1'b0;
  endtask

  task automatic write_settings(input cfg_t s);
    // upper byte of the coefficient writes is don't-care: randomise it
    write_reg(REG_COEF_CUR, {8'($urandom), s.coef_cur}, 1'b0);
    write_reg(REG_COEF_PREV, {8'($urandom), s.coef_prev}, 1'b0);
    write_reg(REG_START_CUR, s.start_cur, 1'b0);
    write_reg(REG_START_PREV, s.start_prev, 1'b0);
    if ($urandom_range(0, 2) == 0)
      write_reg(CfgIdxW'($urandom_range(RegSpareLo, RegSpareHi)), 16'($urandom), 1'b0);
    write_reg(REG_HALF_LEN, s.half_len, 1'b1);
  endtask

  task automatic send_item(input cmd_op_e op, input logic [7:0] value);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_chan.valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk_i);
    end
    in_chan.valid      <= 1'b1;
    in_chan.opcode     <= op;
    in_chan.byte_value <= value;
    do @(posedge clk_i); while (!in_chan.ready);
  endtask

  task automatic send_ticks(input int unsigned n);
    // byte field is ignored on ticks; keep it toggling anyway
    for (int unsigned i = 0; i < n; i++) send_item(OP_TICK, 8'($urandom));
  endtask

  // Drop valid, wait for every sample due, then let the pipeline drain a byte beat too
  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    do @(negedge clk_i); while (samples_due != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Mostly whole frames with idle ticks after; the rest cut short so bytes wait or overwrite
  task automatic run_frames(input int unsigned half_len, input int unsigned n_items);
    int unsigned sent;
    int unsigned span;
    sent = 0;
    while (sent < n_items) begin
      send_item(OP_BYTE, draw_byte());
      if ($urandom_range(0, 3) != 0) span = HalvesPerFrame * half_len + $urandom_range(0, 6);
      else span = $urandom_range(1, HalvesPerFrame * half_len);
      send_ticks(span);
      sent += span + 1;
    end
  endtask

  initial begin : sink_side
    int unsigned gap_left;
    gap_left = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (sink_hold) begin
        // hold off long enough for the block to fill and stall its input
        out_chan.ready <= 1'b0;
        repeat (SinkHoldCycles) @(posedge clk_i);
        sink_hold = 1'b0;
      end else if (gap_left != 0) begin
        out_chan.ready <= 1'b0;
        gap_left--;
      end else begin
        out_chan.ready <= 1'b1;
        if (!quiet && $urandom_range(0, 3) == 0) gap_left = pick_gap();
      end
    end
  end

  initial begin : stimulus
    cfg_t setting;
    in_chan.valid       <= 1'b0;
    in_chan.opcode      <= OP_TICK;
    in_chan.byte_value  <= '0;
    cfg_chan.valid      <= 1'b0;
    cfg_chan.index      <= '0;
    cfg_chan.data       <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // start bit and the first data bit on the reset settings
    send_item(OP_TICK, 8'hFF);
    send_item(OP_BYTE, 8'hA5);
    send_ticks(4 * int'(HalfLenRst));
    wait_idle();
    // finish the current half, then the rest of the frame on one-tick halves and a few idle ticks
    write_reg(REG_HALF_LEN, 16'd1, 1'b1);
    send_ticks(int'(HalfLenRst) + HalvesPerFrame);
    wait_idle();

    // extreme weights and start values, shortest halves
    setting.coef_cur   = 8'sh7f;
    setting.coef_prev  = 8'sh80;
    setting.start_cur  = 16'sh7fff;
    setting.start_prev = 16'sh8000;
    setting.half_len   = 16'd1;
    write_reg(CfgIdxW'(RegSpareLo), 16'hFFFF, 1'b0);
    write_settings(setting);
    send_item(OP_TICK, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, 8'h00);
    // overwrites the waiting byte
    send_item(OP_BYTE, 8'h80);
    // frame ends and the waiting byte starts on the same tick
    send_ticks(HalvesPerFrame + 1);
    wait_idle();

    for (int unsigned p = 0; p < RandPhases; p++) begin
      setting = draw_settings();
      quiet   = ($urandom_range(0, 4) == 0);
      write_settings(setting);
      if (p == HoldPhase) begin
        quiet     = 1'b0;
        sink_hold = 1'b1;
      end
      run_frames(setting.half_len, ItemsPerPhase);
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("tb_manchester_ask_modulator: clean");
    end else begin
      $display("tb_manchester_ask_modulator: errors");
    end
    $finish;
  end

endmodule
